### rtl/sds_pkg.sv
package sds_pkg;

	// Set geometry
	localparam int CAPACITY = 1024;
	localparam int DESC_W   = 10;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Operation codes
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_DEL = 2'd1;
	localparam logic [1:0] KIND_POP = 2'd2;

	// Status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOCHANGE = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// One position table entry: present flag and slot in the member array
	typedef struct packed {
		logic             present;
		logic [POS_W-1:0] slot;
	} pos_entry_t;

	// One response
	typedef struct packed {
		logic [1:0]        status;
		logic [DESC_W-1:0] popped;
		logic [CNT_W-1:0]  member_count;
	} rsp_t;

endpackage

### rtl/sparse_descriptor_set_unit.sv
// Add, pop and a delete that removes nothing load the response from the EXEC state; a delete that
// removes a member passes EXEC and then FIX first. While the response register is full, the result waits in HOLD.
// The position and member memories are read into registers when the request is taken and
// written back in EXEC; a delete needs a second write to the position table, in FIX.
// A new request is taken only after the last response has been loaded, back in IDLE.
// Reset: count clears at once; the position table is then swept to absent,
// one entry per cycle until all entries are swept, during which no request is taken.
module sparse_descriptor_set_unit
	import sds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        kind,
	input  logic [DESC_W-1:0] descriptor,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [DESC_W-1:0] popped,
	output logic [CNT_W-1:0]  member_count
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIX  = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	// Memories
	pos_entry_t        pos_mem [CAPACITY];
	logic [DESC_W-1:0] mem_array [CAPACITY];

	logic [1:0]        state_q;
	logic              clearing_q;
	logic [POS_W-1:0]  clr_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        kind_q;
	logic [DESC_W-1:0] desc_q;
	pos_entry_t        pos_rd_s1;
	logic [DESC_W-1:0] last_rd_s1;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              rsp_free;
	logic              rsp_load;
	logic [CNT_W-1:0]  last_cnt;
	logic              in_range;
	logic [POS_W-1:0]  del_slot;
	logic [DESC_W-1:0] moved;
	logic              moved_ok;
	logic              popped_ok;
	rsp_t              res_d;
	logic [CNT_W-1:0]  count_d;
	logic              del_done;

	logic              pos_we;
	logic [POS_W-1:0]  pos_waddr;
	pos_entry_t        pos_wdata;
	logic              mem_we;
	logic [POS_W-1:0]  mem_waddr;
	logic [DESC_W-1:0] mem_wdata;

	assign req_ready = (state_q == S_IDLE) && !clearing_q;
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign last_cnt  = count_q - CNT_W'(1);
	assign rsp_load  = rsp_free && ((state_q == S_EXEC && !del_done) || state_q == S_FIX
		|| state_q == S_HOLD);

	// Decide the operation from the read data
	always_comb begin
		in_range  = 32'(desc_q) < CAPACITY;
		del_slot  = POS_W'(last_cnt);
		if (CNT_W'(pos_rd_s1.slot) < last_cnt) begin
			del_slot = pos_rd_s1.slot;
		end
		moved_ok  = 32'(last_rd_s1) < CAPACITY;
		moved     = moved_ok ? last_rd_s1 : desc_q;
		popped_ok = 32'(last_rd_s1) < CAPACITY;
		res_d     = '{status: ST_NOCHANGE, popped: '0, member_count: count_q};
		count_d   = count_q;
		del_done  = 1'b0;
		pos_we    = 1'b0;
		pos_waddr = POS_W'(desc_q);
		pos_wdata = '{present: 1'b0, slot: '0};
		mem_we    = 1'b0;
		mem_waddr = POS_W'(count_q);
		mem_wdata = desc_q;
		case (state_q)
			S_EXEC: begin
				case (kind_q)
					KIND_ADD: begin
						if (!in_range) begin
							res_d.status = ST_RANGE;
						end else if (!pos_rd_s1.present || 32'(count_q) >= CAPACITY) begin
							res_d.status = pos_rd_s1.present ? ST_NOCHANGE : ST_NOCHANGE;
						end
						if (in_range && !pos_rd_s1.present && 32'(count_q) < CAPACITY) begin
							res_d.status = ST_DONE;
							count_d      = count_q + CNT_W'(1);
							pos_we       = 1'b1;
							pos_wdata    = '{present: 1'b1, slot: POS_W'(count_q)};
							mem_we       = 1'b1;
						end
					end
					KIND_DEL: begin
						if (!in_range) begin
							res_d.status = ST_RANGE;
						end else if (pos_rd_s1.present && count_q != '0) begin
							res_d.status = ST_DONE;
							del_done     = 1'b1;
							count_d      = last_cnt;
							pos_we       = 1'b1;
							pos_waddr    = POS_W'(moved);
							pos_wdata    = '{present: 1'b1, slot: del_slot};
							mem_we       = 1'b1;
							mem_waddr    = del_slot;
							mem_wdata    = moved;
						end
					end
					KIND_POP: begin
						if (count_q == '0) begin
							res_d.status = ST_EMPTY;
						end else begin
							res_d.status = ST_DONE;
							res_d.popped = last_rd_s1;
							count_d      = last_cnt;
							pos_we       = popped_ok;
							pos_waddr    = POS_W'(last_rd_s1);
						end
					end
					default: begin
						res_d.status = ST_NOCHANGE;
					end
				endcase
				res_d.member_count = count_d;
			end
			S_FIX: begin
				// Drop the deleted descriptor last so it wins over the move
				pos_we = 1'b1;
			end
			default: begin
				pos_we = 1'b0;
			end
		endcase
		if (clearing_q) begin
			pos_we    = 1'b1;
			pos_waddr = clr_idx_q;
			pos_wdata = '{present: 1'b0, slot: '0};
		end
	end

	// Position table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		if (accept) begin
			pos_rd_s1 <= pos_mem[POS_W'(descriptor)];
		end
	end

	// Member array: one write port, one registered read port at the last slot
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_array[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			last_rd_s1 <= mem_array[POS_W'(last_cnt)];
		end
	end

	// Hold request fields and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			desc_q <= descriptor;
		end
		if (state_q == S_EXEC) begin
			res_q <= res_d;
		end
	end

	// Control: clearing sweep, sequencer, count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + POS_W'(1);
				if (clr_idx_q == POS_W'(CAPACITY - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= count_d;
					if (del_done) begin
						state_q <= S_FIX;
					end else if (rsp_free) begin
						rsp_q   <= res_d;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_FIX, S_HOLD: begin
					if (rsp_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign popped       = rsp_q.popped;
	assign member_count = rsp_q.member_count;

endmodule

### rtl/sds_checker.sv
module sds_checker
	import sds_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [1:0]        kind,
	input logic [DESC_W-1:0] descriptor,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [DESC_W-1:0] popped,
	input logic [CNT_W-1:0]  member_count
);

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(popped)
			&& $stable(member_count))
		else $error("stalled response changed");

	// One request at a time: ready drops after a taken request
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// Empty status only with an empty set
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> member_count == '0)
		else $error("empty status with members");

	// Popped value is zero unless the operation was done
	a_popped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DONE |-> popped == '0)
		else $error("popped value without a done pop");

	// Count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(member_count) <= CAPACITY)
		else $error("member count above capacity");

endmodule

bind sparse_descriptor_set_unit sds_checker u_sds_checker (.*);

### verif/sparse_descriptor_set_unit_test.sv
module sparse_descriptor_set_unit_test;
	import sds_pkg::*;

	// kind 3 has no operation behind it and must leave the set alone
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 1_000_000;
	localparam int RANDOM_REQUESTS = 350;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [1:0]        kind = KIND_ADD;
	logic [DESC_W-1:0] descriptor = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [1:0]        status;
	logic [DESC_W-1:0] popped;
	logic [CNT_W-1:0]  member_count;

	// Shadow copy of the set
	bit                is_member [CAPACITY];
	bit [CNT_W-1:0]    slot_of [CAPACITY];
	bit [DESC_W-1:0]   dense [CAPACITY];
	bit [CNT_W-1:0]    set_size = '0;

	rsp_t awaited_rsp [$];
	int   error_count = 0;
	int   cycle_count = 0;
	int   send_quiet = 0;
	int   recv_quiet = 0;

	sparse_descriptor_set_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Apply one request to the shadow set and return the response it must produce
	function automatic rsp_t apply_set_op(input logic [1:0] op, input logic [DESC_W-1:0] d);
		rsp_t            r;
		bit [CNT_W-1:0]  slot;
		bit [CNT_W-1:0]  last;
		bit [DESC_W-1:0] moved;
		r.status = ST_NOCHANGE;
		r.popped = '0;
		case (op)
			KIND_ADD: begin
				if (int'(d) >= CAPACITY)
					r.status = ST_RANGE;
				else if (!is_member[d] && set_size < CAPACITY) begin
					slot_of[d] = set_size;
					is_member[d] = 1'b1;
					dense[set_size[DESC_W-1:0]] = d;
					set_size = set_size + 1'b1;
					r.status = ST_DONE;
				end
			end
			KIND_DEL: begin
				if (int'(d) >= CAPACITY)
					r.status = ST_RANGE;
				else if (is_member[d] && set_size != 0) begin
					slot = slot_of[d];
					last = set_size - 1'b1;
					if (slot > last)
						slot = last;
					// fill the hole with the last member
					moved = dense[last[DESC_W-1:0]];
					dense[slot[DESC_W-1:0]] = moved;
					slot_of[moved] = slot;
					dense[last[DESC_W-1:0]] = '0;
					is_member[d] = 1'b0;
					slot_of[d] = '0;
					set_size = last;
					r.status = ST_DONE;
				end
			end
			KIND_POP: begin
				if (set_size == 0)
					r.status = ST_EMPTY;
				else begin
					last = set_size - 1'b1;
					r.popped = dense[last[DESC_W-1:0]];
					dense[last[DESC_W-1:0]] = '0;
					is_member[r.popped] = 1'b0;
					slot_of[r.popped] = '0;
					set_size = last;
					r.status = ST_DONE;
				end
			end
			default: r.status = ST_NOCHANGE;
		endcase
		r.member_count = set_size;
		return r;
	endfunction

	// Present one request after a random gap and hold it until taken
	task automatic send_request(input logic [1:0] op, input logic [DESC_W-1:0] d);
		int gap;
		if (send_quiet > 0) begin
			send_quiet--;
			gap = 0;
		end else if ($urandom_range(0, 39) == 0) begin
			send_quiet = $urandom_range(8, 30);
			gap = 0;
		end else
			gap = $urandom_range(0, 18);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= op;
		descriptor <= d;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		awaited_rsp.push_back(apply_set_op(op, d));
	endtask

	// Drop valid and wait for every outstanding response
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	// Accept responses with random stalls and compare against the shadow set
	initial begin
		rsp_t want;
		int   stall;
		@(posedge arst_n);
		forever begin
			if (recv_quiet > 0) begin
				recv_quiet--;
				stall = 0;
			end else if ($urandom_range(0, 39) == 0) begin
				recv_quiet = $urandom_range(8, 30);
				stall = 0;
			end else
				stall = $urandom_range(0, 18);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			if (awaited_rsp.size() == 0) begin
				$error("unexpected response: status %0d popped %0d member_count %0d",
					status, popped, member_count);
				error_count++;
			end else begin
				want = awaited_rsp.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (popped !== want.popped) begin
					$error("popped: expected %0d, got %0d", want.popped, popped);
					error_count++;
				end
				if (member_count !== want.member_count) begin
					$error("member_count: expected %0d, got %0d",
						want.member_count, member_count);
					error_count++;
				end
			end
		end
	end

	// Pop, delete and the unused kind on a freshly reset set
	task automatic test_empty_set();
		send_request(KIND_POP, 10'd0);
		send_request(KIND_DEL, 10'd0);
		send_request(KIND_DEL, 10'd1023);
		send_request(KIND_UNUSED, 10'd0);
		send_request(KIND_UNUSED, 10'd1023);
		drain();
	endtask

	// Add, re-add, delete from the middle, delete twice, pop down to empty
	task automatic test_basic_ops();
		send_request(KIND_ADD, 10'd0);
		send_request(KIND_ADD, 10'd1023);
		send_request(KIND_ADD, 10'd0);
		send_request(KIND_ADD, 10'd512);
		send_request(KIND_ADD, 10'd1);
		send_request(KIND_DEL, 10'd1023);
		send_request(KIND_DEL, 10'd1023);
		send_request(KIND_UNUSED, 10'd341);
		send_request(KIND_DEL, 10'd1);
		send_request(KIND_ADD, 10'd682);
		send_request(KIND_POP, 10'd1023);
		send_request(KIND_POP, 10'd0);
		send_request(KIND_ADD, 10'd1023);
		send_request(KIND_POP, 10'd0);
		send_request(KIND_POP, 10'd0);
		send_request(KIND_POP, 10'd0);
		drain();
	endtask

	// Fill every descriptor in shuffled order and leave the set full
	task automatic test_fill_to_capacity();
		int order [CAPACITY];
		int pick;
		int hold;
		foreach (order[i])
			order[i] = i;
		for (int i = CAPACITY - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			hold = order[i];
			order[i] = order[pick];
			order[pick] = hold;
		end
		foreach (order[i])
			send_request(KIND_ADD, DESC_W'(order[i]));
		// a full set must refuse another add
		send_request(KIND_ADD, DESC_W'($urandom_range(0, CAPACITY - 1)));
		send_request(KIND_UNUSED, DESC_W'($urandom_range(0, CAPACITY - 1)));
		drain();
	endtask

	// Mixed traffic over descriptor pools of changing size and add bias
	task automatic test_random_mix();
		int                base;
		int                mask;
		int                add_weight;
		int                roll;
		logic [1:0]        op;
		logic [DESC_W-1:0] d;
		base = 0;
		mask = 'h3FF;
		add_weight = 50;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0) begin
				base = $urandom_range(0, CAPACITY - 1);
				case ($urandom_range(0, 2))
					0: mask = 'hF;
					1: mask = 'h3F;
					default: mask = 'h3FF;
				endcase
				add_weight = $urandom_range(30, 65);
			end
			d = DESC_W'(base ^ ($urandom & mask));
			roll = $urandom_range(0, 99);
			if (roll < add_weight)
				op = KIND_ADD;
			else if (roll < add_weight + 25) begin
				op = KIND_DEL;
				// aim half of the deletes at a current member
				if (set_size != 0 && $urandom_range(0, 1))
					d = dense[DESC_W'($urandom_range(0, set_size - 1))];
			end else if (roll < 96)
				op = KIND_POP;
			else
				op = KIND_UNUSED;
			send_request(op, d);
		end
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_set();
		test_basic_ops();
		test_fill_to_capacity();
		test_random_mix();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
